// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define IOTR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in the same cycle as the trigger
`define IOTR_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// condition in the cycle after the trigger
`define IOTR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/iotr_pkg.sv =====
// types, constants and helpers for the in-order transfer receiver
package iotr_pkg;

    localparam int SEQ_W       = 15;
    localparam int LEN_W       = 10;
    localparam int TIMER_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SEQ_W-1:0]   SEQ_MOD       = 15'd25601;
    localparam logic [LEN_W-1:0]   MAX_PAYLOAD   = 10'd512;
    localparam logic [SEQ_W-1:0]   INIT_SEQ_RST  = 15'd0;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST   = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_SEQUENCE = 1'b0,
        CFG_TIMEOUT_TICKS    = 1'b1
    } cfg_index_t;

    typedef enum logic {
        CMD_HEADER = 1'b0,
        CMD_TICK   = 1'b1
    } command_t;

    typedef struct packed {
        logic             command;
        logic [SEQ_W-1:0] seq_number;
        logic [LEN_W-1:0] payload_length;
        logic             ack_bit;
        logic             syn_bit;
        logic             fin_bit;
    } in_t;

    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] out_sequence;
        logic [SEQ_W-1:0] out_acknowledge;
        logic             out_ack_bit;
        logic             out_syn_bit;
        logic             out_fin_bit;
        logic             duplicate;
        logic             resend;
        logic             timed_out;
        logic             deliver;
        logic             closed;
        logic             last;
    } out_t;

    // one classified item: one or two results
    typedef struct packed {
        logic two;
        out_t r0;
        out_t r1;
    } job_t;

    // values stay below twice the modulus, so one subtract is enough
    function automatic logic [SEQ_W-1:0] mod_reduce(input logic [SEQ_W:0] v);
        logic [SEQ_W:0] d;
        d = v - {1'b0, SEQ_MOD};
        return (v >= {1'b0, SEQ_MOD}) ? d[SEQ_W-1:0] : v[SEQ_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/in_order_transfer_receiver.sv =====
// top level of the in-order transfer receiver
// Receiver end of a reliable transfer with sequence numbers modulo 25601. Each
// input transfer is a packet header or a timer tick; a new one is taken every
// clock cycle while the job queue (QUEUE_DEPTH entries) has room. Most inputs
// give one result, a FIN gives two (FIN-ACK then FIN), and ticks in the open
// phase or that only count the wait timer give none. The output side sends one
// result per cycle while out_stall is low, so a run of FINs, each giving two
// results, fills the job queue and stalls the input. Each result passes through
// the job queue and then the output register. Configuration writes are taken
// at any time but must only be issued while the block holds no pending work.
module in_order_transfer_receiver #(
    parameter int QUEUE_DEPTH = iotr_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  iotr_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output iotr_pkg::out_t                  out_data,
    input  logic                            cfg_write,
    input  logic [iotr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iotr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iotr_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_job;
    job_t head_job;

    assign in_stall = full;

    iotr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .queue_full (full),
        .in_data    (in_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_job   (push_job)
    );

    iotr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_job (head_job)
    );

    iotr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/iotr_front.sv =====
// front end: connection state, classification and result building
module iotr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            queue_full,
    input  iotr_pkg::in_t                   in_data,
    input  logic                            cfg_write,
    input  logic [iotr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iotr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            push,
    output iotr_pkg::job_t                  push_job
);
    import iotr_pkg::*;
    `include "assert_macros.svh"

    logic               closing_reg, closing_next;
    logic               first_syn_reg, first_syn_next;
    logic [SEQ_W-1:0]   send_seq_reg, send_seq_next;
    logic [SEQ_W-1:0]   expected_reg, expected_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [SEQ_W-1:0]   init_seq_reg;
    logic [TIMER_W-1:0] timeout_reg;

    logic               accept;
    logic [LEN_W-1:0]   len_sat;
    logic [SEQ_W-1:0]   seq_plus_one;
    logic [SEQ_W-1:0]   seq_plus_len;
    logic [SEQ_W-1:0]   send_inc;
    logic [SEQ_W-1:0]   send_now;
    logic [SEQ_W-1:0]   init_mod;

    assign accept   = in_valid && !queue_full;
    assign len_sat  = (in_data.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                             : in_data.payload_length;
    assign seq_plus_one = mod_reduce({1'b0, in_data.seq_number} + 16'd1);
    assign seq_plus_len = mod_reduce({1'b0, in_data.seq_number}
                                     + {{(SEQ_W + 1 - LEN_W){1'b0}}, len_sat});
    assign send_inc = mod_reduce({1'b0, send_seq_reg} + 16'd1);
    assign send_now = in_data.ack_bit ? send_inc : send_seq_reg;
    assign init_mod = mod_reduce({1'b0, init_seq_reg});

    always_comb
    begin
        closing_next   = closing_reg;
        first_syn_next = first_syn_reg;
        send_seq_next  = send_seq_reg;
        expected_next  = expected_reg;
        timer_next     = timer_reg;
        push           = 1'b0;
        push_job       = '0;
        if (accept)
        begin
            if (!closing_reg)
            begin
                if (command_t'(in_data.command) == CMD_HEADER)
                begin
                    push = 1'b1;
                    if (in_data.syn_bit)
                    begin
                        push_job.r0.send_valid      = 1'b1;
                        push_job.r0.out_sequence    = send_seq_reg;
                        push_job.r0.out_acknowledge = seq_plus_one;
                        push_job.r0.out_ack_bit     = 1'b1;
                        push_job.r0.out_syn_bit     = 1'b1;
                        push_job.r0.duplicate       = !first_syn_reg;
                        push_job.r0.last            = 1'b1;
                        expected_next  = seq_plus_one;
                        first_syn_next = 1'b0;
                    end
                    else if (in_data.fin_bit)
                    begin
                        // fin-ack, then our own fin
                        push_job.two                = 1'b1;
                        push_job.r0.send_valid      = 1'b1;
                        push_job.r0.out_sequence    = send_seq_reg;
                        push_job.r0.out_acknowledge = seq_plus_one;
                        push_job.r0.out_ack_bit     = 1'b1;
                        push_job.r1.send_valid      = 1'b1;
                        push_job.r1.out_sequence    = send_seq_reg;
                        push_job.r1.out_fin_bit     = 1'b1;
                        push_job.r1.last            = 1'b1;
                        closing_next = 1'b1;
                        timer_next   = timeout_reg;
                    end
                    else
                    begin
                        send_seq_next               = send_now;
                        push_job.r0.send_valid      = 1'b1;
                        push_job.r0.out_sequence    = send_now;
                        push_job.r0.out_ack_bit     = 1'b1;
                        push_job.r0.last            = 1'b1;
                        if (in_data.seq_number == expected_reg)
                        begin
                            push_job.r0.out_acknowledge = seq_plus_len;
                            push_job.r0.deliver         = 1'b1;
                            expected_next               = seq_plus_len;
                        end
                        else
                        begin
                            push_job.r0.out_acknowledge = expected_reg;
                            push_job.r0.duplicate       = 1'b1;
                        end
                    end
                end
            end
            else if (command_t'(in_data.command) == CMD_TICK)
            begin
                if (timer_reg <= 16'd1)
                begin
                    push                     = 1'b1;
                    push_job.r0.send_valid   = 1'b1;
                    push_job.r0.out_sequence = send_seq_reg;
                    push_job.r0.out_fin_bit  = 1'b1;
                    push_job.r0.resend       = 1'b1;
                    push_job.r0.timed_out    = 1'b1;
                    push_job.r0.last         = 1'b1;
                    timer_next               = timeout_reg;
                end
                else
                begin
                    timer_next = timer_reg - 16'd1;
                end
            end
            else if (in_data.fin_bit)
            begin
                push                        = 1'b1;
                push_job.two                = 1'b1;
                push_job.r0.send_valid      = 1'b1;
                push_job.r0.out_sequence    = send_seq_reg;
                push_job.r0.out_acknowledge = seq_plus_one;
                push_job.r0.out_ack_bit     = 1'b1;
                push_job.r1.send_valid      = 1'b1;
                push_job.r1.out_sequence    = send_seq_reg;
                push_job.r1.out_fin_bit     = 1'b1;
                push_job.r1.resend          = 1'b1;
                push_job.r1.last            = 1'b1;
                timer_next                  = timeout_reg;
            end
            else
            begin
                // final ack, connection finished
                push               = 1'b1;
                push_job.r0.closed = 1'b1;
                push_job.r0.last   = 1'b1;
                closing_next       = 1'b0;
                first_syn_next     = 1'b1;
                timer_next         = '0;
                send_seq_next      = init_mod;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closing_reg   <= 1'b0;
            first_syn_reg <= 1'b1;
            send_seq_reg  <= INIT_SEQ_RST;
            expected_reg  <= '0;
            timer_reg     <= '0;
            init_seq_reg  <= INIT_SEQ_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else
        begin
            closing_reg   <= closing_next;
            first_syn_reg <= first_syn_next;
            send_seq_reg  <= send_seq_next;
            expected_reg  <= expected_next;
            timer_reg     <= timer_next;
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_INITIAL_SEQUENCE: init_seq_reg <= cfg_data[SEQ_W-1:0];
                    CFG_TIMEOUT_TICKS:    timeout_reg  <= cfg_data[TIMER_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    `IOTR_ASSERT_SAME(a_open_timer_idle, !closing_reg, timer_reg == '0,
        "wait timer running in open phase")
    `IOTR_ASSERT_ALWAYS(a_send_seq_range, send_seq_reg < SEQ_MOD,
        "send sequence out of range")

endmodule

// ===== hw/rtl/iotr_queue.sv =====
// short job queue between front and back end
module iotr_queue #(
    parameter int DEPTH = iotr_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  iotr_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output iotr_pkg::job_t head_job
);
    import iotr_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `IOTR_ASSERT_SAME(a_no_overflow, push, !full || pop, "push into a full queue")
    `IOTR_ASSERT_SAME(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

// ===== hw/rtl/iotr_back.sv =====
// back end: splits each job into its results and drives the output register
module iotr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  iotr_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output iotr_pkg::out_t out_data
);
    import iotr_pkg::*;
    `include "assert_macros.svh"

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg, out_data_next;
    logic phase_reg, phase_next;
    logic load;

    // output register may take a new result when empty or being drained
    assign load      = !out_valid_reg || !out_stall;
    assign pop       = load && !empty && (!head_job.two || phase_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_data_next = phase_reg ? head_job.r1 : head_job.r0;
                phase_next    = head_job.two && !phase_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `IOTR_ASSERT_SAME(a_phase_two, phase_reg, !empty && head_job.two,
        "second result pending without a two-result job")

endmodule

// ===== bench/iotr_reply_checker.sv =====
`timescale 1ns / 1ps
// reply checker for the in-order transfer receiver: predicts replies and compares them
module iotr_reply_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  iotr_pkg::in_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  iotr_pkg::out_t                  out_data,
    input  logic                            cfg_write,
    input  logic [iotr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iotr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending,
    output logic [iotr_pkg::SEQ_W-1:0]      rx_expected,
    output logic                            rx_closing
);
    import iotr_pkg::*;

    localparam int SPAN        = int'(SEQ_MOD);
    localparam int PAYLOAD_CAP = int'(MAX_PAYLOAD);

    logic closing;
    logic syn_pending;
    int   snd_seq;
    int   exp_seq;
    int   fin_timer;
    int   init_seq_reg;
    int   timeout_reg;
    out_t replies[$];
    out_t want;

    assign rx_expected = exp_seq[SEQ_W-1:0];
    assign rx_closing  = closing;

    function automatic out_t make_reply(input bit v, input int sq, input int ak,
                                        input bit fa, input bit fs, input bit ff,
                                        input bit dup, input bit rs, input bit to,
                                        input bit dl, input bit cl, input bit lst);
        out_t r;
        r.send_valid      = v;
        r.out_sequence    = sq[SEQ_W-1:0];
        r.out_acknowledge = ak[SEQ_W-1:0];
        r.out_ack_bit     = fa;
        r.out_syn_bit     = fs;
        r.out_fin_bit     = ff;
        r.duplicate       = dup;
        r.resend          = rs;
        r.timed_out       = to;
        r.deliver         = dl;
        r.closed          = cl;
        r.last            = lst;
        return r;
    endfunction

    function automatic string reply_text(input out_t r);
        return $sformatf({"valid=%0b seq=%0d ack=%0d flags(a,s,f)=%0b%0b%0b dup=%0b ",
                          "resend=%0b timed_out=%0b deliver=%0b closed=%0b last=%0b"},
                         r.send_valid, r.out_sequence, r.out_acknowledge, r.out_ack_bit,
                         r.out_syn_bit, r.out_fin_bit, r.duplicate, r.resend,
                         r.timed_out, r.deliver, r.closed, r.last);
    endfunction

    task automatic predict_replies(input in_t it);
        int len;
        int sq;
        int ak;
        len = int'(it.payload_length);
        if (len > PAYLOAD_CAP)
            len = PAYLOAD_CAP;
        sq = int'(it.seq_number);
        if (!closing)
        begin
            if (it.command == CMD_TICK)
            begin
                // ticks do nothing while the connection is open
            end
            else if (it.syn_bit)
            begin
                ak = (sq + 1) % SPAN;
                replies.push_back(make_reply(1, snd_seq, ak, 1, 1, 0, !syn_pending,
                                             0, 0, 0, 0, 1));
                exp_seq     = ak;
                syn_pending = 1'b0;
            end
            else if (it.fin_bit)
            begin
                replies.push_back(make_reply(1, snd_seq, (sq + 1) % SPAN, 1, 0, 0,
                                             0, 0, 0, 0, 0, 0));
                replies.push_back(make_reply(1, snd_seq, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
                closing   = 1'b1;
                fin_timer = timeout_reg;
            end
            else
            begin
                if (it.ack_bit)
                    snd_seq = (snd_seq + 1) % SPAN;
                if (sq == exp_seq)
                begin
                    replies.push_back(make_reply(1, snd_seq, (sq + len) % SPAN, 1, 0, 0,
                                                 0, 0, 0, 1, 0, 1));
                    exp_seq = (exp_seq + len) % SPAN;
                end
                else
                    replies.push_back(make_reply(1, snd_seq, exp_seq, 1, 0, 0,
                                                 1, 0, 0, 0, 0, 1));
            end
        end
        else if (it.command == CMD_TICK)
        begin
            if (fin_timer <= 1)
            begin
                replies.push_back(make_reply(1, snd_seq, 0, 0, 0, 1, 0, 1, 1, 0, 0, 1));
                fin_timer = timeout_reg;
            end
            else
                fin_timer = fin_timer - 1;
        end
        else if (it.fin_bit)
        begin
            replies.push_back(make_reply(1, snd_seq, (sq + 1) % SPAN, 1, 0, 0,
                                         0, 0, 0, 0, 0, 0));
            replies.push_back(make_reply(1, snd_seq, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1));
            fin_timer = timeout_reg;
        end
        else
        begin
            // final ack: connection done, back to open with a fresh send sequence
            replies.push_back(make_reply(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
            closing     = 1'b0;
            syn_pending = 1'b1;
            fin_timer   = 0;
            snd_seq     = init_seq_reg % SPAN;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_seq_reg = int'(INIT_SEQ_RST);
            timeout_reg  = int'(TIMEOUT_RST);
            closing      = 1'b0;
            syn_pending  = 1'b1;
            snd_seq      = init_seq_reg % SPAN;
            exp_seq      = 0;
            fin_timer    = 0;
            replies.delete();
            errors       = 0;
            pending      = 0;
        end
        else
        begin
            // retire the result first so a transfer taken on this edge cannot match it
            if (out_valid && !out_stall)
            begin
                if (replies.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected reply at %0t: %s", $realtime,
                                 reply_text(out_data));
                end
                else
                begin
                    want = replies.pop_front();
                    if (out_data.send_valid !== want.send_valid ||
                        out_data.out_sequence !== want.out_sequence ||
                        out_data.out_acknowledge !== want.out_acknowledge ||
                        out_data.out_ack_bit !== want.out_ack_bit ||
                        out_data.out_syn_bit !== want.out_syn_bit ||
                        out_data.out_fin_bit !== want.out_fin_bit ||
                        out_data.duplicate !== want.duplicate ||
                        out_data.resend !== want.resend ||
                        out_data.timed_out !== want.timed_out ||
                        out_data.deliver !== want.deliver ||
                        out_data.closed !== want.closed ||
                        out_data.last !== want.last)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("reply mismatch at %0t: expected %s, got %s",
                                     $realtime, reply_text(want), reply_text(out_data));
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_replies(in_data);
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_INITIAL_SEQUENCE: init_seq_reg = int'(cfg_data[SEQ_W-1:0]);
                    CFG_TIMEOUT_TICKS:    timeout_reg  = int'(cfg_data);
                    default:              ;
                endcase
            end
            pending = replies.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the in-order transfer receiver: stimulus, reset and verdict
module tb;
    import iotr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    errors;
    int                    pending;
    logic [SEQ_W-1:0]      rx_expected;
    logic                  rx_closing;

    bit                    calm;
    int                    sent;

    in_order_transfer_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iotr_reply_checker reply_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .rx_expected (rx_expected),
        .rx_closing  (rx_closing)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int n;
        if (calm)
            n = 0;
        else
            n = $urandom_range(0, 6);
        return n;
    endfunction

    function automatic bit coin();
        return bit'($urandom_range(0, 1));
    endfunction

    function automatic int rand_seq();
        return $urandom_range(0, 32767);
    endfunction

    // mostly ordinary lengths, with zero, the cap and oversized ones mixed in
    function automatic int rand_len();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 10)
            len = 0;
        else if (r < 20)
            len = 512;
        else if (r < 30)
            len = $urandom_range(513, 1023);
        else
            len = $urandom_range(1, 511);
        return len;
    endfunction

    function automatic in_t mk(input command_t c, input int sq, input int len,
                               input bit a, input bit s, input bit f);
        in_t it;
        it.command        = c;
        it.seq_number     = sq[SEQ_W-1:0];
        it.payload_length = len[LEN_W-1:0];
        it.ack_bit        = a;
        it.syn_bit        = s;
        it.fin_bit        = f;
        return it;
    endfunction

    function automatic in_t noise_item();
        logic [31:0] w;
        w = $urandom;
        return w[$bits(in_t)-1:0];
    endfunction

    function automatic in_t tick_item();
        return mk(CMD_TICK, rand_seq(), $urandom_range(0, 1023), coin(), coin(), coin());
    endfunction

    // in_order: take the sequence number the receiver expects when the transfer is driven
    task automatic send_item(input in_t it, input bit in_order);
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        if (in_order)
            it.seq_number = rx_expected;
        if (it.command == CMD_HEADER || rx_closing)
            sent = sent + 1;
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending until every reply is back, then let in-flight ticks drain
    task automatic hold_off();
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic configure(input int init_val, input int ticks);
        hold_off();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_INITIAL_SEQUENCE;
        cfg_data  <= init_val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= ticks[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_session();
        int r;
        send_item(mk(CMD_HEADER, rand_seq(), rand_len(), coin(), 1'b1, coin() & coin()), 0);
        repeat ($urandom_range(2, 14))
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_item(mk(CMD_HEADER, 0, rand_len(), coin(), 1'b0, 1'b0), 1);
            else if (r < 75)
                send_item(mk(CMD_HEADER, rand_seq(), rand_len(), coin(), 1'b0, 1'b0), 0);
            else if (r < 83)
                send_item(tick_item(), 0);
            else if (r < 90)
                send_item(mk(CMD_HEADER, rand_seq(), rand_len(), coin(), 1'b1, coin()), 0);
            else
                send_item(noise_item(), 0);
        end
        send_item(mk(CMD_HEADER, rand_seq(), rand_len(), coin(), 1'b0, 1'b1), 0);
        repeat ($urandom_range(0, 8))
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_item(tick_item(), 0);
            else if (r < 92)
                send_item(mk(CMD_HEADER, rand_seq(), rand_len(), coin(), coin(), 1'b1), 0);
            else
                send_item(noise_item(), 0);
        end
        // final ack closes the connection
        send_item(mk(CMD_HEADER, rand_seq(), rand_len(), coin(), coin(), 1'b0), 0);
    endtask

    // result side: random stall before each transfer
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        int p;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        sent      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings: open phase corner cases, then a full close
        send_item(mk(CMD_TICK, 0, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(mk(CMD_HEADER, 0, 1023, 1'b1, 1'b1, 1'b0), 0);
        send_item(mk(CMD_HEADER, 32767, 0, 1'b0, 1'b1, 1'b1), 0);
        send_item(mk(CMD_HEADER, 0, 0, 1'b1, 1'b0, 1'b0), 1);
        send_item(mk(CMD_HEADER, 0, 1023, 1'b0, 1'b0, 1'b0), 1);
        send_item(mk(CMD_HEADER, 25600, 5, 1'b1, 1'b0, 1'b0), 0);
        send_item(mk(CMD_HEADER, 32767, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(mk(CMD_HEADER, 0, 512, 1'b1, 1'b0, 1'b0), 1);
        send_item(mk(CMD_HEADER, 25600, 0, 1'b1, 1'b0, 1'b1), 0);
        send_item(mk(CMD_TICK, 0, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(mk(CMD_HEADER, 32767, 1023, 1'b1, 1'b1, 1'b1), 0);
        send_item(mk(CMD_HEADER, 1, 0, 1'b1, 1'b0, 1'b0), 0);

        // initial sequence 25600 is loaded at this section's close; timer expires on every tick
        configure(25600, 1);
        send_item(mk(CMD_HEADER, 0, 7, 1'b1, 1'b0, 1'b0), 1);
        send_item(mk(CMD_HEADER, 25600, 0, 1'b0, 1'b1, 1'b0), 0);
        send_item(mk(CMD_HEADER, 100, 0, 1'b0, 1'b0, 1'b1), 0);
        send_item(mk(CMD_TICK, 0, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(mk(CMD_TICK, 32767, 1023, 1'b1, 1'b1, 1'b1), 0);
        send_item(mk(CMD_HEADER, 5, 3, 1'b0, 1'b1, 1'b0), 0);

        // out-of-range initial sequence and a zero timeout
        configure(32'hFFFF, 0);
        send_item(mk(CMD_HEADER, 25599, 0, 1'b0, 1'b0, 1'b1), 0);
        send_item(mk(CMD_TICK, 0, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(mk(CMD_HEADER, 0, 0, 1'b0, 1'b0, 1'b0), 0);
        send_item(mk(CMD_HEADER, 0, 1, 1'b1, 1'b0, 1'b0), 1);

        sent = 0;
        p    = 0;
        while (sent < 600)
        begin
            if (sent >= p * 100)
            begin
                case (p % 6)
                    0: configure(12345, 3);
                    1: configure(0, 1);
                    2: configure(25600, 2);
                    3: configure($urandom_range(0, 25600), $urandom_range(1, 6));
                    4: configure($urandom_range(25601, 32767), 65535);
                    default: configure($urandom_range(0, 25600), 500);
                endcase
                calm = ($urandom_range(0, 3) == 0);
                p = p + 1;
            end
            if ($urandom_range(0, 99) < 4)
                hold_off();
            run_session();
        end

        hold_off();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
